### hdl/sorted_insert_pop_min_list_top_macros.svh
// Assertion macros shared by the checker of the sorted list queue.
`ifndef SORTED_INSERT_POP_MIN_LIST_TOP_MACROS_SVH
`define SORTED_INSERT_POP_MIN_LIST_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SIPML_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sipml assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SIPML_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sipml assertion failed");

`endif

### hdl/sipml_pkg.sv
// Types and codes shared by the sorted list queue modules.
`timescale 1ns / 1ps
`default_nettype none
package sipml_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain at once.
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_step_t;

endpackage
`default_nettype wire

### hdl/sorted_insert_pop_min_list_top.sv
// Top level of the sorted list queue: a chain of compare-and-shift cells.
//
// The input channel (in_valid/in_ready) carries items of kind and value. Kind
// insert places value after every stored value that is not greater; kind remove
// takes out the smallest stored value. Each accepted item yields one result
// transfer on the output channel (out_valid/out_ready) with status, the removed
// value, the entry count and the smallest value left in the list.
// Every cell compares its entry with the new value in parallel and the whole row
// shifts at once, so the result is registered and offered in the cycle after the
// input transfer. An item can be taken every cycle while results keep draining.
// An insert into a full list leaves the list as it is and reports full; a remove
// from an empty list reports empty.
// Reset empties the list; the entry cells themselves are not cleared.
// While a result waits with out_ready low, in_ready is held low and the result
// and the list stay unchanged until the output transfer completes.
`timescale 1ns / 1ps
`default_nettype none
module sorted_insert_pop_min_list_top #(
    parameter int DEPTH = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    kind,
    input  wire sipml_pkg::data_t  value,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [1:0]             status,
    output sipml_pkg::data_t       removed_value,
    output logic                   removed_valid,
    output logic [4:0]             entry_count,
    output sipml_pkg::data_t       front_value,
    output logic                   front_valid
);
    import sipml_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    data_t            removed_value_reg;
    data_t            removed_value_next;
    logic             removed_valid_reg;
    logic             removed_valid_next;
    logic [4:0]       entry_count_reg;
    logic [4:0]       entry_count_next;
    data_t            front_value_reg;
    data_t            front_value_next;
    logic             front_valid_reg;
    logic             front_valid_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_step_t       step;
    data_t            cell_value [DEPTH];
    logic             cell_le    [DEPTH];
    logic [31:0]      count_wide;

    // Handshake: a new item enters when the output register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign step.ins = accept && (kind == KIND_INSERT) && !is_full;
    assign step.rem = accept && (kind == KIND_REMOVE) && !is_empty;

    // Row of cells; cell 0 always sees a left neighbor that stops the walk.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic  left_le_w;
        data_t left_value_w;
        data_t right_value_w;

        if (i == 0)
        begin : g_first
            assign left_le_w    = 1'b1;
            assign left_value_w = value;
        end
        else
        begin : g_mid
            assign left_le_w    = cell_le[i-1];
            assign left_value_w = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value_w = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value_w = cell_value[i+1];
        end

        sipml_cell u_cell (
            .clk         (clk),
            .step        (step),
            .new_value   (value),
            .occupied    (count_reg > CNT_W'(i)),
            .left_le     (left_le_w),
            .left_value  (left_value_w),
            .right_value (right_value_w),
            .value       (cell_value[i]),
            .le          (cell_le[i])
        );
    end

    // Result of the item, formed from the list as it stands before the shift.
    always_comb
    begin
        count_next         = count_reg;
        status_next        = ST_DONE;
        removed_value_next = '0;
        removed_valid_next = 1'b0;
        front_value_next   = is_empty ? data_t'(0) : cell_value[0];

        if (kind == KIND_INSERT)
        begin
            if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next       = count_reg + CNT_W'(1);
                front_value_next = cell_le[0] ? cell_value[0] : value;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next         = count_reg - CNT_W'(1);
                removed_value_next = cell_value[0];
                removed_valid_next = 1'b1;
                front_value_next   = (count_reg > CNT_W'(1)) ? cell_value[1] : data_t'(0);
            end
        end

        count_wide       = 32'(count_next);
        entry_count_next = count_wide[4:0];
        front_valid_next = (count_next != '0);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            removed_value_reg <= removed_value_next;
            removed_valid_reg <= removed_valid_next;
            entry_count_reg   <= entry_count_next;
            front_value_reg   <= front_value_next;
            front_valid_reg   <= front_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_value_reg;
    assign removed_valid = removed_valid_reg;
    assign entry_count   = entry_count_reg;
    assign front_value   = front_value_reg;
    assign front_valid   = front_valid_reg;

endmodule
`default_nettype wire

### hdl/sipml_cell.sv
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module sipml_cell (
    input  wire                      clk,
    input  wire sipml_pkg::cell_step_t step,
    input  wire sipml_pkg::data_t    new_value,
    input  wire                      occupied,
    input  wire                      left_le,
    input  wire sipml_pkg::data_t    left_value,
    input  wire sipml_pkg::data_t    right_value,
    output sipml_pkg::data_t         value,
    output logic                     le
);
    import sipml_pkg::*;

    data_t value_reg;
    data_t value_next;

    // The entry stays put when it is stored and not greater than the new value.
    assign le    = occupied && (value_reg <= new_value);
    assign value = value_reg;

    // On insert the first cell past the stop point takes the new value and the
    // cells behind it shift one place back; on remove every cell pulls from the right.
    always_comb
    begin
        value_next = value_reg;
        if (step.ins)
        begin
            if (le)
            begin
                value_next = value_reg;
            end
            else if (left_le)
            begin
                value_next = new_value;
            end
            else
            begin
                value_next = left_value;
            end
        end
        else if (step.rem)
        begin
            value_next = right_value;
        end
    end

    // Entry register, no reset: only occupied cells are ever read.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

### hdl/sipml_checker.sv
// Port-level checker for the sorted list queue and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_pop_min_list_top_macros.svh"
module sipml_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    out_valid,
    input wire                    out_ready,
    input wire [1:0]              status,
    input wire sipml_pkg::data_t  removed_value,
    input wire                    removed_valid,
    input wire [4:0]              entry_count,
    input wire                    front_valid
);
    import sipml_pkg::*;

    // A stalled result stays offered.
    `SIPML_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A removed value only comes with a successful item.
    `SIPML_ASSERT_NOW(a_removed_done, clk, rst_n, out_valid && removed_valid, status == ST_DONE)

    // A refused remove means the list was and stays empty.
    `SIPML_ASSERT_NOW(a_empty_report, clk, rst_n, out_valid && status == ST_EMPTY,
        !front_valid && entry_count == 5'd0)

    // No removed value is shown without its valid flag.
    `SIPML_ASSERT_NOW(a_removed_zero, clk, rst_n, out_valid && !removed_valid,
        removed_value == 0)

endmodule

bind sorted_insert_pop_min_list_top sipml_checker u_sipml_checker (.*);
`default_nettype wire
